[src/mmh_pkg.sv]
// shared constants, job record and back-end state codes for the murmur3 x64 128 hasher
// no dependencies; compile first
package mmh_pkg;

  // mixing constants
  localparam logic [63:0] MIX_C1    = 64'h87c3_7b91_1142_53d5;
  localparam logic [63:0] MIX_C2    = 64'h4cf5_ad43_2745_937f;
  localparam logic [63:0] LANE1_ADD = 64'h0000_0000_52dc_e729;
  localparam logic [63:0] LANE2_ADD = 64'h0000_0000_3849_5ab5;
  localparam logic [63:0] FMIX_M1   = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] FMIX_M2   = 64'hc4ce_b9fe_1a85_ec53;

  // length saturates here
  localparam logic [31:0] LEN_LIMIT = 32'h8000_0000;

  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned JOB_Q_DEPTH = 2;
  localparam int unsigned JOB_Q_AW    = (JOB_Q_DEPTH > 1) ? $clog2(JOB_Q_DEPTH) : 1;

  // one unit of work for the back end
  typedef struct packed {
    logic        blk;    // mix a full block
    logic        fin;    // finalize and emit
    logic        first;  // load seed into lanes before anything else
    logic [31:0] seed;
    logic [63:0] w0;     // little-endian bytes 0..7 (tail bytes zero padded)
    logic [63:0] w1;     // bytes 8..15
    logic [31:0] len;
  } mmh_job_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_K1A,
    ST_K1B,
    ST_LN1A,
    ST_LN1B,
    ST_K2A,
    ST_K2B,
    ST_LN2A,
    ST_LN2B,
    ST_XLEN,
    ST_ADD2,
    ST_F1A,
    ST_F1B,
    ST_F2A,
    ST_F2B,
    ST_FXS,
    ST_SUM1,
    ST_SUM2,
    ST_EMIT
  } back_st_e;

  function automatic logic [63:0] rotl64(logic [63:0] v, int unsigned r);
    return (v << r) | (v >> (64 - r));
  endfunction

  function automatic logic [63:0] xs33(logic [63:0] v);
    return v ^ (v >> 33);
  endfunction

endpackage

[src/mmh_ifs.sv]
// valid/ready channel interfaces: message input, seed write, hash output
// no dependencies
interface mmh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_byte;

  modport source (output valid, data_byte, byte_present, last_byte, input ready);
  modport sink   (input valid, data_byte, byte_present, last_byte, output ready);
endinterface

interface mmh_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] seed;

  modport source (output valid, seed, input ready);
  modport sink   (input valid, seed, output ready);
endinterface

interface mmh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_first;
  logic [63:0] hash_second;
  logic        length_overflow;

  modport source (output valid, hash_first, hash_second, length_overflow, input ready);
  modport sink   (input valid, hash_first, hash_second, length_overflow, output ready);
endinterface

[src/mmh_front.sv]
// front end: takes byte beats, gathers 16-byte blocks, tracks length and message start
// depends on mmh_pkg and mmh_ifs
module mmh_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  mmh_in_if.sink            in_if,
  mmh_cfg_if.sink           cfg_if,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output mmh_pkg::mmh_job_t push_job_o
);
  import mmh_pkg::*;

  logic [8*BLOCK_BYTES-1:0] asm_q, asm_d, asm_base, asm_ins;
  logic [3:0]               fill_q, fill_d, fill_base;
  logic [31:0]              len_q, len_d, len_base, len_ins;
  logic [31:0]              seed_q, msg_seed_q, msg_seed_d, msg_seed_base;
  logic                     in_msg_q, in_msg_d;
  logic                     first_q, first_d, first_base;
  logic                     start, beat, full;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = push_ready_i;
  assign beat         = in_if.valid && in_if.ready;

  always_comb begin
    start         = !in_msg_q;
    fill_base     = start ? 4'd0 : fill_q;
    len_base      = start ? 32'd0 : len_q;
    asm_base      = start ? '0 : asm_q;
    first_base    = start ? 1'b1 : first_q;
    msg_seed_base = start ? seed_q : msg_seed_q;

    asm_ins = asm_base;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if (in_if.byte_present && fill_base == 4'(i)) begin
        asm_ins[8*i +: 8] = in_if.data_byte;
      end
    end

    len_ins = len_base;
    if (in_if.byte_present && len_base < LEN_LIMIT) begin
      len_ins = len_base + 32'd1;
    end

    full = in_if.byte_present && fill_base == 4'(BLOCK_BYTES - 1);

    push_valid_o     = beat && (full || in_if.last_byte);
    push_job_o.blk   = full;
    push_job_o.fin   = in_if.last_byte;
    push_job_o.first = first_base;
    push_job_o.seed  = msg_seed_base;
    push_job_o.w0    = asm_ins[63:0];
    push_job_o.w1    = asm_ins[127:64];
    push_job_o.len   = len_ins;

    asm_d      = asm_q;
    fill_d     = fill_q;
    len_d      = len_q;
    msg_seed_d = msg_seed_q;
    in_msg_d   = in_msg_q;
    first_d    = first_q;
    if (beat) begin
      asm_d      = full ? '0 : asm_ins;
      fill_d     = in_if.byte_present ? fill_base + 4'd1 : fill_base;
      len_d      = len_ins;
      msg_seed_d = msg_seed_base;
      first_d    = (full || in_if.last_byte) ? 1'b0 : first_base;
      in_msg_d   = !in_if.last_byte;
      if (in_if.last_byte) begin
        fill_d = 4'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= '0;
      fill_q   <= '0;
      len_q    <= '0;
      in_msg_q <= 1'b0;
      first_q  <= 1'b0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        seed_q <= cfg_if.seed;
      end
      fill_q   <= fill_d;
      len_q    <= len_d;
      in_msg_q <= in_msg_d;
      first_q  <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    asm_q      <= asm_d;
    msg_seed_q <= msg_seed_d;
  end

endmodule

[src/mmh_job_q.sv]
// small fifo of jobs between front and back end
// depends on mmh_pkg
module mmh_job_q (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  mmh_pkg::mmh_job_t push_job_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output mmh_pkg::mmh_job_t pop_job_o
);
  import mmh_pkg::*;

  mmh_job_t            mem_q [JOB_Q_DEPTH];
  logic [JOB_Q_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [JOB_Q_AW:0]   cnt_q;
  logic                do_push, do_pop;

  assign push_ready_o = cnt_q != (JOB_Q_AW + 1)'(JOB_Q_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  function automatic logic [JOB_Q_AW-1:0] next_ptr(logic [JOB_Q_AW-1:0] p);
    return (p == JOB_Q_AW'(JOB_Q_DEPTH - 1)) ? '0 : p + JOB_Q_AW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (JOB_Q_AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (JOB_Q_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

[src/mmh_back.sv]
// back end: lane mixing and finalization on one shared 32x32 multiplier, plus output register
// depends on mmh_pkg and mmh_ifs
module mmh_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  mmh_pkg::mmh_job_t pop_job_i,
  mmh_out_if.source         out_if
);
  import mmh_pkg::*;

  back_st_e    st_q, st_d;
  logic [1:0]  ph_q, ph_d;
  logic [63:0] p_q, p_d, acc_q, acc_d;
  logic [63:0] h1_q, h1_d, h2_q, h2_d, k_q, k_d, w0_q, w0_d, w1_q, w1_d;
  logic [31:0] len_q, len_d;
  logic        blk_q, blk_d, fin_q, fin_d;
  logic        ovld_q, ovld_d;
  logic [63:0] ofirst_q, ofirst_d, osecond_q, osecond_d;
  logic        oovf_q, oovf_d;
  logic [63:0] mul_a, mul_b, mul_res, len64;
  logic [31:0] mul_x, mul_y;
  logic        mul_done;

  assign out_if.valid           = ovld_q;
  assign out_if.hash_first      = ofirst_q;
  assign out_if.hash_second     = osecond_q;
  assign out_if.length_overflow = oovf_q;

  // 64x64 low product in four phases: lo*lo, lo*hi, hi*lo, then sum
  always_comb begin
    unique case (st_q)
      ST_K1A:  begin mul_a = w0_q;              mul_b = MIX_C1;  end
      ST_K1B:  begin mul_a = rotl64(k_q, 31);   mul_b = MIX_C2;  end
      ST_K2A:  begin mul_a = w1_q;              mul_b = MIX_C2;  end
      ST_K2B:  begin mul_a = rotl64(k_q, 33);   mul_b = MIX_C1;  end
      ST_F1A:  begin mul_a = xs33(h1_q);        mul_b = FMIX_M1; end
      ST_F1B:  begin mul_a = xs33(h1_q);        mul_b = FMIX_M2; end
      ST_F2A:  begin mul_a = xs33(h2_q);        mul_b = FMIX_M1; end
      ST_F2B:  begin mul_a = xs33(h2_q);        mul_b = FMIX_M2; end
      default: begin mul_a = '0;                mul_b = '0;      end
    endcase
    mul_x    = (ph_q == 2'd2) ? mul_a[63:32] : mul_a[31:0];
    mul_y    = (ph_q == 2'd1) ? mul_b[63:32] : mul_b[31:0];
    p_d      = mul_x * mul_y;
    mul_res  = acc_q + {p_q[31:0], 32'h0};
    mul_done = ph_q == 2'd3;
    acc_d    = (ph_q == 2'd1) ? p_q : mul_res;
  end

  always_comb begin
    len64       = {32'h0, len_q};
    st_d        = st_q;
    ph_d        = 2'd0;
    h1_d        = h1_q;
    h2_d        = h2_q;
    k_d         = k_q;
    w0_d        = w0_q;
    w1_d        = w1_q;
    len_d       = len_q;
    blk_d       = blk_q;
    fin_d       = fin_q;
    pop_ready_o = 1'b0;
    ovld_d      = ovld_q && !out_if.ready;
    ofirst_d    = ofirst_q;
    osecond_d   = osecond_q;
    oovf_d      = oovf_q;

    unique case (st_q)
      ST_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          w0_d  = pop_job_i.w0;
          w1_d  = pop_job_i.w1;
          len_d = pop_job_i.len;
          blk_d = pop_job_i.blk;
          fin_d = pop_job_i.fin;
          if (pop_job_i.first) begin
            h1_d = {32'h0, pop_job_i.seed};
            h2_d = {32'h0, pop_job_i.seed};
          end
          st_d = ST_K1A;
        end
      end
      ST_K1A, ST_K1B, ST_K2A, ST_K2B: begin
        if (mul_done) begin
          k_d = mul_res;
          unique case (st_q)
            ST_K1A:  st_d = ST_K1B;
            ST_K1B:  st_d = ST_LN1A;
            ST_K2A:  st_d = ST_K2B;
            default: st_d = ST_LN2A;
          endcase
        end else begin
          ph_d = ph_q + 2'd1;
        end
      end
      ST_LN1A: begin
        if (blk_q) begin
          h1_d = rotl64(h1_q ^ k_q, 27) + h2_q;
          st_d = ST_LN1B;
        end else begin
          h1_d = h1_q ^ k_q;
          st_d = ST_K2A;
        end
      end
      ST_LN1B: begin
        h1_d = h1_q + {h1_q[61:0], 2'b00} + LANE1_ADD;
        st_d = ST_K2A;
      end
      ST_LN2A: begin
        if (blk_q) begin
          h2_d = rotl64(h2_q ^ k_q, 31) + h1_q;
          st_d = ST_LN2B;
        end else begin
          h2_d = h2_q ^ k_q;
          st_d = ST_XLEN;
        end
      end
      ST_LN2B: begin
        h2_d = h2_q + {h2_q[61:0], 2'b00} + LANE2_ADD;
        if (fin_q) begin
          // block closed the message: rerun the tail pass with an empty tail
          w0_d  = '0;
          w1_d  = '0;
          blk_d = 1'b0;
          st_d  = ST_K1A;
        end else begin
          st_d = ST_IDLE;
        end
      end
      ST_XLEN: begin
        h1_d = (h1_q ^ len64) + (h2_q ^ len64);
        h2_d = h2_q ^ len64;
        st_d = ST_ADD2;
      end
      ST_ADD2: begin
        h2_d = h2_q + h1_q;
        st_d = ST_F1A;
      end
      ST_F1A, ST_F1B: begin
        if (mul_done) begin
          h1_d = mul_res;
          st_d = (st_q == ST_F1A) ? ST_F1B : ST_F2A;
        end else begin
          ph_d = ph_q + 2'd1;
        end
      end
      ST_F2A, ST_F2B: begin
        if (mul_done) begin
          h2_d = mul_res;
          st_d = (st_q == ST_F2A) ? ST_F2B : ST_FXS;
        end else begin
          ph_d = ph_q + 2'd1;
        end
      end
      ST_FXS: begin
        h1_d = xs33(h1_q);
        h2_d = xs33(h2_q);
        st_d = ST_SUM1;
      end
      ST_SUM1: begin
        h1_d = h1_q + h2_q;
        st_d = ST_SUM2;
      end
      ST_SUM2: begin
        h2_d = h2_q + h1_q;
        st_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!ovld_q || out_if.ready) begin
          ovld_d    = 1'b1;
          ofirst_d  = h1_q;
          osecond_d = h2_q;
          oovf_d    = len_q[31];
          st_d      = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      ph_q   <= '0;
      ovld_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      ph_q   <= ph_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q       <= p_d;
    acc_q     <= acc_d;
    h1_q      <= h1_d;
    h2_q      <= h2_d;
    k_q       <= k_d;
    w0_q      <= w0_d;
    w1_q      <= w1_d;
    len_q     <= len_d;
    blk_q     <= blk_d;
    fin_q     <= fin_d;
    ofirst_q  <= ofirst_d;
    osecond_q <= osecond_d;
    oovf_q    <= oovf_d;
  end

endmodule

[src/murmur3_x64_128_hash.sv]
// top level of the streaming murmurhash3 x64 128-bit hasher
// depends on mmh_pkg, mmh_ifs, mmh_front, mmh_job_q, mmh_back
//
//  channel  dir  beat carries                              handshake
//  in_i     in   data_byte, byte_present, last_byte        valid/ready
//  cfg_i    in   seed (32 bit)                             valid/ready, ready always high
//  out_o    out  hash_first, hash_second, length_overflow  valid/ready
//
// the front takes one byte beat per cycle while the job queue has room
// a full block costs the back end a pop, four lane steps and four 64-bit multiplies
//   on one shared 32x32 multiplier; a final beat runs the tail pass, length fold,
//   fmix and output, after the block mixing when it also closes a full block
// jobs are popped only in idle, so the back-end multiplier sets the sustained rate
// reset clears all control state at once; no clearing pass
// a stalled output register holds one hash, the back end holds the next,
//   the front keeps going until the job queue is full
module murmur3_x64_128_hash (
  input  logic       clk_i,
  input  logic       rst_ni,
  mmh_in_if.sink     in_i,
  mmh_cfg_if.sink    cfg_i,
  mmh_out_if.source  out_o
);
  import mmh_pkg::*;

  // front to queue
  logic     push_valid, push_ready;
  mmh_job_t push_job;
  // queue to back
  logic     pop_valid, pop_ready;
  mmh_job_t pop_job;

  // byte gathering, length count, seed capture at message start
  mmh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_i),
    .cfg_if       (cfg_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  // decouples byte intake from the long mixing jobs
  mmh_job_q u_job_q (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  // lane mixing, tail, length fold, fmix and output register
  mmh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .out_if      (out_o)
  );

endmodule

[src/mmh_checker.sv]
// port-level checks for the murmur3 hasher, bound to the top level
// depends on murmur3_x64_128_hash and mmh_ifs
module mmh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        cfg_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_first_i,
  input logic [63:0] out_second_i,
  input logic        out_ovf_i
);

  logic [3:0] pend_q;
  logic       in_last_beat, out_beat;

  assign in_last_beat = in_valid_i && in_ready_i && in_last_i;
  assign out_beat     = out_valid_i && out_ready_i;

  // messages closed but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + (in_last_beat ? 4'd1 : 4'd0) - (out_beat ? 4'd1 : 4'd0);
    end
  end

  a_no_spurious_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 4'd0)
    else $error("hash offered with no closed message pending");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_first_i)
      && $stable(out_second_i) && $stable(out_ovf_i))
    else $error("stalled hash beat changed");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

  a_cfg_always_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("seed write port not ready");

endmodule

bind murmur3_x64_128_hash mmh_checker u_mmh_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_last_i    (in_i.last_byte),
  .cfg_ready_i  (cfg_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_first_i  (out_o.hash_first),
  .out_second_i (out_o.hash_second),
  .out_ovf_i    (out_o.length_overflow)
);
